// ===== sv/ptrs_pkg.sv =====
// Package for the periodic timer rearm engine: payload types, codes, state
// enum and the widths shared by the top level, the divider and the channels.
// No dependencies.
package ptrs_pkg;

  localparam int TIME_WIDTH_DEF = 48;   // default internal time width
  localparam int TIME_FIELD_W   = 48;   // width of the time fields on the channels
  localparam int CNT_W          = 32;
  localparam int LAT_W          = 32;
  localparam int TOT_W          = 64;
  localparam int IV_W           = 26;   // 65535 ms * 1000 fits in 26 bits
  localparam int US_PER_MS      = 1000;
  localparam int INTERVAL_MS_RST = 1000;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ALIGNED = 1'd1;

  localparam logic [1:0] CMD_FIRE    = 2'd0;
  localparam logic [1:0] CMD_STATS   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;   // reports like stats, clears nothing

  localparam int DIV_DVD_W          = 64;
  localparam int DIV_DSR_W          = 32;
  localparam int DIV_BITS_PER_CYCLE = 2;

  localparam logic [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};
  localparam logic [LAT_W-1:0] LAT_MAX = {1'b0, {(LAT_W-1){1'b1}}};
  localparam logic [LAT_W-1:0] LAT_MIN = {1'b1, {(LAT_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAT,
    ST_STAT,
    ST_SLOTW,
    ST_NEXT,
    ST_SKIP,
    ST_RST,
    ST_MEAN,
    ST_MEANW,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [TIME_FIELD_W-1:0] now_us;
    logic [TIME_FIELD_W-1:0] horizon_us;
  } in_item_t;

  typedef struct packed {
    logic [TIME_FIELD_W-1:0] next_expiry_us;
    logic [CNT_W-1:0]        slots_accounted;
    logic [CNT_W-1:0]        overrun_total;
    logic signed [LAT_W-1:0] max_latency_us;
    logic signed [TOT_W-1:0] total_latency_us;
    logic [CNT_W-1:0]        latency_samples;
    logic signed [LAT_W-1:0] mean_latency_us;
  } out_item_t;

endpackage

// ===== sv/ptrs_if.sv =====
// Valid/ready channels of the timer rearm engine: request in, result out.
// Depends on ptrs_pkg for the payload types.
interface ptrs_in_if;
  import ptrs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptrs_out_if;
  import ptrs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/periodic_timer_rearm_stats.sv =====
// Periodic timer rearm engine: expiry, latency statistics, overrun count.
// Depends on ptrs_pkg, the channel interfaces in ptrs_if and ptrs_div.
//
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   command, now_us, horizon_us
//  out_o    out  valid/ready   next_expiry_us .. mean_latency_us
//  cfg      in   cfg_we_i      cfg_index_i, cfg_wdata_i
//
// Each division holds the sequencer on the shared divider, once for the slot
// count on a fire and once for the mean when there are samples.
// One request at a time; in_i.ready is high only while idle.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only when its own result is ready to load.
// Reset: expiry = 1000000 us, statistics and overrun count cleared.
module periodic_timer_rearm_stats #(
  parameter int TIME_WIDTH = ptrs_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ptrs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  ptrs_in_if.sink                          in_i,
  ptrs_out_if.source                       out_o
);
  import ptrs_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TMAX    = {TIME_WIDTH{1'b1}};
  localparam logic [IV_W-1:0]       IV_RST  = IV_W'(INTERVAL_MS_RST * US_PER_MS);

  state_e state_q, state_d;

  // configuration
  logic [IV_W-1:0] iv_q;
  logic            skip_q;
  logic [CFG_DATA_W-1:0] ms_eff;

  // request and statistics
  logic [1:0]              cmd_q;
  logic [TIME_WIDTH-1:0]   now_q, hz_q, exp_q;
  logic signed [LAT_W-1:0] maxlat_q;
  logic signed [TOT_W-1:0] total_q;
  logic [CNT_W-1:0]        cnt_q, ovr_q;

  // working registers
  logic signed [TOT_W-1:0] lat_q;
  logic                    hz_gt_q;
  logic [DIV_DVD_W-1:0]    slots_q;
  logic [TIME_WIDTH-1:0]   base_q, next1_q;
  logic [CNT_W-1:0]        slots_acc_q;
  logic signed [LAT_W-1:0] mean_q;

  out_item_t out_q;
  logic      out_vld_q;

  // divider hookup
  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dvd, div_quot;
  logic [DIV_DSR_W-1:0] div_dsr, div_rem;
  div_stat_t            div_stat;

  logic in_acc, out_load;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_OUT) && (!out_vld_q || out_o.ready);

  // ---------------- configuration ----------------
  assign ms_eff = (cfg_wdata_i == '0) ? CFG_DATA_W'(1) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q   <= IV_RST;
      skip_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_INTERVAL_MS:  iv_q   <= IV_W'(ms_eff) * IV_W'(US_PER_MS);
        REG_SKIP_ALIGNED: skip_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath logic ----------------
  logic [TIME_WIDTH-1:0] iv_tw, add_a, add_res;
  logic [TIME_WIDTH:0]   add_sum;
  logic [TOT_W:0]        lat_diff;
  logic signed [TOT_W-1:0] lat_sat, tot_sum, tot_next, abs_in;
  logic                  tot_ovf, lat_fits;
  logic signed [LAT_W-1:0] lat32, mean_n;
  logic [CNT_W-1:0]      slots_acc;
  logic [CNT_W:0]        ovr_sum;

  assign iv_tw = TIME_WIDTH'(iv_q);

  // Shared saturating time adder: aligned base, request time or expiry plus one interval
  always_comb begin
    case (state_q)
      ST_SKIP: add_a = base_q;
      ST_RST:  add_a = now_q;
      default: add_a = exp_q;
    endcase
  end
  assign add_sum = (TIME_WIDTH+1)'(add_a) + (TIME_WIDTH+1)'(iv_tw);
  assign add_res = add_sum[TIME_WIDTH] ? TMAX : add_sum[TIME_WIDTH-1:0];

  // Latency, clamped to the signed 64-bit range
  assign lat_diff = (TOT_W+1)'(now_q) - (TOT_W+1)'(exp_q);
  assign lat_sat  = (lat_diff[TOT_W] != lat_diff[TOT_W-1]) ?
                    (lat_diff[TOT_W] ? TOT_MIN : TOT_MAX) : lat_diff[TOT_W-1:0];

  assign lat_fits = (&lat_q[TOT_W-1:LAT_W-1]) || !(|lat_q[TOT_W-1:LAT_W-1]);
  assign lat32    = lat_fits ? lat_q[LAT_W-1:0] : (lat_q[TOT_W-1] ? LAT_MIN : LAT_MAX);

  assign tot_sum  = total_q + lat_q;
  assign tot_ovf  = (total_q[TOT_W-1] == lat_q[TOT_W-1]) &&
                    (tot_sum[TOT_W-1] != lat_q[TOT_W-1]);
  assign tot_next = tot_ovf ? (lat_q[TOT_W-1] ? TOT_MIN : TOT_MAX) : tot_sum;

  assign slots_acc = skip_q ?
                     ((|slots_q[DIV_DVD_W-1:CNT_W]) ? CNT_MAX : slots_q[CNT_W-1:0]) :
                     CNT_W'(|slots_q);
  assign ovr_sum   = {1'b0, ovr_q} + {1'b0, slots_acc};

  assign abs_in = total_q[TOT_W-1] ? -total_q : total_q;

  // Mean from the magnitude quotient, sign restored and clamped to 32 bits
  always_comb begin
    if (total_q[TOT_W-1]) begin
      mean_n = (div_quot > DIV_DVD_W'(64'h8000_0000)) ? LAT_MIN : -div_quot[LAT_W-1:0];
    end else begin
      mean_n = (div_quot > DIV_DVD_W'(64'h7FFF_FFFF)) ? LAT_MAX : div_quot[LAT_W-1:0];
    end
  end

  // Divider: slot count on a fire, then the mean on every request with samples
  assign div_start = (state_q == ST_STAT) || ((state_q == ST_MEAN) && (cnt_q != '0));
  assign div_dvd   = (state_q == ST_STAT) ?
                     (hz_gt_q ? DIV_DVD_W'(hz_q - exp_q) : '0) : abs_in;
  assign div_dsr   = (state_q == ST_STAT) ? DIV_DSR_W'(iv_q) : cnt_q;

  ptrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.data.command)
            CMD_FIRE:    state_d = ST_LAT;
            CMD_RESTART: state_d = ST_RST;
            default:     state_d = ST_MEAN;
          endcase
        end
      end
      ST_LAT:   state_d = ST_STAT;
      ST_STAT:  state_d = ST_SLOTW;
      ST_SLOTW: if (div_stat.done) state_d = ST_NEXT;
      ST_NEXT:  state_d = ST_SKIP;
      ST_SKIP:  state_d = ST_MEAN;
      ST_RST:   state_d = ST_MEAN;
      ST_MEAN:  state_d = (cnt_q == '0) ? ST_OUT : ST_MEANW;
      ST_MEANW: if (div_stat.done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------- state and statistics ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q    <= TIME_WIDTH'(IV_RST);
      maxlat_q <= '0;
      total_q  <= '0;
      cnt_q    <= '0;
      ovr_q    <= '0;
    end else begin
      case (state_q)
        ST_STAT: begin
          if (lat32 > maxlat_q) maxlat_q <= lat32;
          total_q <= tot_next;
          if (cnt_q != CNT_MAX) cnt_q <= cnt_q + 1'b1;
        end
        ST_SKIP: begin
          exp_q <= (skip_q && (next1_q <= hz_q)) ? add_res : next1_q;
          ovr_q <= ovr_sum[CNT_W] ? CNT_MAX : ovr_sum[CNT_W-1:0];
        end
        ST_RST: exp_q <= add_res;
        ST_OUT: begin
          // clear on a stats request once the report is loaded into the output register
          if (out_load && (cmd_q == CMD_STATS)) begin
            maxlat_q <= '0;
            total_q  <= '0;
            cnt_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q       <= in_i.data.command;
      now_q       <= TIME_WIDTH'(in_i.data.now_us);
      hz_q        <= TIME_WIDTH'(in_i.data.horizon_us);
      slots_acc_q <= '0;
    end
    case (state_q)
      ST_LAT: begin
        lat_q   <= lat_sat;
        hz_gt_q <= (hz_q > exp_q);
      end
      ST_SLOTW: begin
        if (div_stat.done) begin
          slots_q <= div_quot;
          // expiry plus whole slots equals horizon less the remainder
          base_q  <= hz_gt_q ? (hz_q - TIME_WIDTH'(div_rem)) : exp_q;
        end
      end
      ST_NEXT: next1_q <= add_res;
      ST_SKIP: slots_acc_q <= slots_acc;
      ST_MEAN: if (cnt_q == '0) mean_q <= '0;
      ST_MEANW: if (div_stat.done) mean_q <= mean_n;
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.next_expiry_us   <= TIME_FIELD_W'(exp_q);
      out_q.slots_accounted  <= slots_acc_q;
      out_q.overrun_total    <= ovr_q;
      out_q.max_latency_us   <= maxlat_q;
      out_q.total_latency_us <= total_q;
      out_q.latency_samples  <= cnt_q;
      out_q.mean_latency_us  <= mean_q;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // ---------------- assertions ----------------
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready) else $error("request taken while busy");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy) else $error("divider restarted while busy");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_STAT && state_q != ST_OUT) |=> $stable(cnt_q))
    else $error("sample count moved outside update or clear");

  a_exp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SKIP && state_q != ST_RST) |=> $stable(exp_q))
    else $error("expiry moved outside rearm");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_OUT))
    else $error("result shown without a finished request");

endmodule

// ===== sv/ptrs_div.sv =====
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on ptrs_pkg for widths and the status struct.
module ptrs_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ptrs_pkg::DIV_DVD_W-1:0]   dividend_i,
  input  logic [ptrs_pkg::DIV_DSR_W-1:0]   divisor_i,
  output ptrs_pkg::div_stat_t              stat_o,
  output logic [ptrs_pkg::DIV_DVD_W-1:0]   quot_o,
  output logic [ptrs_pkg::DIV_DSR_W-1:0]   rem_o
);
  import ptrs_pkg::*;

  localparam int STEPS  = DIV_DVD_W / DIV_BITS_PER_CYCLE;
  localparam int STEP_W = $clog2(STEPS);

  logic [DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_DSR_W-1:0] rem_q, rem_d;
  logic [DIV_DSR_W-1:0] dsr_q;
  logic [STEP_W-1:0]    step_q;
  logic                 busy_q, done_q;

  always_comb begin
    logic [DIV_DSR_W:0] sh;
    logic               ge;
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      sh    = {rem_d, dvd_d[DIV_DVD_W-1]};
      ge    = (sh >= {1'b0, dsr_q});
      rem_d = ge ? DIV_DSR_W'(sh - {1'b0, dsr_q}) : DIV_DSR_W'(sh);
      dvd_d = {dvd_d[DIV_DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in at the bottom of the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;
  assign rem_o       = rem_q;

endmodule
